>>> design/uvs_pkg.sv
package uvs_pkg;

	localparam int DIV_STEPS = 30;
	localparam int QSIN_LAT = 6;
	localparam int QDEPTH = 16;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam int MAX_SUBDIV_DEF = 256;

	localparam logic [8:0] SUBDIV_RESET = 9'd16;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] POLY_C1 = 31'd1686629713;
	localparam logic [30:0] POLY_C3 = 31'd693598668;
	localparam logic [30:0] POLY_C5 = 31'd85569306;
	localparam logic [30:0] POLY_C7 = 31'd5026995;
	localparam logic [30:0] POLY_C9 = 31'd172272;
	localparam logic [16:0] POS_MAX = 17'd16384;

	// angle jobs issued per cell
	localparam logic [1:0] JOB_ROW0 = 2'd0;
	localparam logic [1:0] JOB_ROW1 = 2'd1;
	localparam logic [1:0] JOB_COL0 = 2'd2;
	localparam logic [1:0] JOB_COL1 = 2'd3;

	localparam logic [2:0] CORNER_LAST = 3'd5;
	// bit k: row or column offset of corner k
	localparam logic [5:0] CORNER_ROW = 6'b011010;
	localparam logic [5:0] CORNER_COL = 6'b110100;

	typedef struct packed {
		logic [1:0][30:0] lat_cos_mag;
		logic [1:0]       lat_cos_neg;
		logic [1:0][15:0] pos_y;
		logic [1:0][30:0] lon_cos_mag;
		logic [1:0]       lon_cos_neg;
		logic [1:0][30:0] lon_sin_mag;
		logic [1:0]       lon_sin_neg;
		logic [1:0][16:0] tex_u;
		logic [1:0][16:0] tex_v;
	} rec_t;

	// saturate a rounded magnitude and apply the sign
	function automatic logic [15:0] pos_round(input logic [16:0] r, input logic neg);
		logic [15:0] m;
		m = (r > POS_MAX) ? POS_MAX[15:0] : r[15:0];
		return neg ? -m : m;
	endfunction

endpackage

>>> design/uvs_div.sv
module uvs_div (
	input  logic                           clk,
	input  logic [9:0]                     rem_in,
	input  logic [9:0]                     den_in,
	input  logic [uvs_pkg::DIV_STEPS-1:0]  feed_in,
	output logic [uvs_pkg::DIV_STEPS-1:0]  quo_out,
	output logic [9:0]                     rem_out
);
	import uvs_pkg::*;

	logic [9:0]           rem_q  [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_q  [DIV_STEPS];
	logic [9:0]           den_q  [DIV_STEPS-1];
	logic [DIV_STEPS-1:0] feed_q [DIV_STEPS-1];

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		logic [9:0]           rem_src;
		logic [9:0]           den_src;
		logic [DIV_STEPS-1:0] quo_src;
		logic [DIV_STEPS-1:0] feed_src;
		logic [10:0]          trial;
		logic                 ge;

		if (g == 0) begin : g_first
			assign rem_src  = rem_in;
			assign den_src  = den_in;
			assign quo_src  = '0;
			assign feed_src = feed_in;
		end else begin : g_next
			assign rem_src  = rem_q[g-1];
			assign den_src  = den_q[g-1];
			assign quo_src  = quo_q[g-1];
			assign feed_src = feed_q[g-1];
		end

		assign trial = {rem_src, feed_src[DIV_STEPS-1]};
		assign ge    = trial >= {1'b0, den_src};

		always_ff @(posedge clk) begin
			rem_q[g] <= ge ? 10'(trial - {1'b0, den_src}) : trial[9:0];
			quo_q[g] <= {quo_src[DIV_STEPS-2:0], ge};
		end

		if (g < DIV_STEPS - 1) begin : g_pass
			always_ff @(posedge clk) begin
				den_q[g]  <= den_src;
				feed_q[g] <= {feed_src[DIV_STEPS-2:0], 1'b0};
			end
		end
	end

	assign quo_out = quo_q[DIV_STEPS-1];
	assign rem_out = rem_q[DIV_STEPS-1];

endmodule

>>> design/uvs_qsin.sv
module uvs_qsin (
	input  logic        clk,
	input  logic [30:0] x,
	output logic [30:0] s
);
	import uvs_pkg::*;

	logic [61:0] m1, m2, m3, m4, m5, m6;
	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [30:0] x2_s1, x2_s2, x2_s3, x2_s4;
	logic [30:0] p_s2, p_s3, p_s4, p_s5;
	logic [30:0] s_s6;

	assign m1 = x * x;
	assign m2 = POLY_C9 * x2_s1;
	assign m3 = p_s2 * x2_s2;
	assign m4 = p_s3 * x2_s3;
	assign m5 = p_s4 * x2_s4;
	assign m6 = p_s5 * x_s5;

	always_ff @(posedge clk) begin
		x_s1  <= x;
		x2_s1 <= m1[60:30];
		x_s2  <= x_s1;
		x2_s2 <= x2_s1;
		p_s2  <= POLY_C7 - m2[60:30];
		x_s3  <= x_s2;
		x2_s3 <= x2_s2;
		p_s3  <= POLY_C5 - m3[60:30];
		x_s4  <= x_s3;
		x2_s4 <= x2_s3;
		p_s4  <= POLY_C3 - m4[60:30];
		x_s5  <= x_s4;
		p_s5  <= POLY_C1 - m5[60:30];
		s_s6  <= m6[60:30];
	end

	assign s = s_s6;

endmodule

>>> design/uvs_front.sv
module uvs_front #(
	parameter int MAX_SUBDIV = uvs_pkg::MAX_SUBDIV_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [8:0]    cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,
	input  logic          pop,
	output logic          rec_valid,
	output uvs_pkg::rec_t rec
);
	import uvs_pkg::*;

	localparam logic [8:0] NCAP = (MAX_SUBDIV > 511) ? 9'd511 : 9'(MAX_SUBDIV);
	localparam int L = QSIN_LAT;

	logic [8:0]       subdiv_q;
	logic [8:0]       n_eff;
	logic [7:0]       lat_c, lon_c;
	logic             accept;
	logic             busy_q;
	logic [1:0]       job_q;
	logic [CNT_W-1:0] cnt_q;
	logic [8:0]       n_q;
	logic [7:0]       i_q, j_q;

	logic             row;
	logic [8:0]       off;
	logic [8:0]       k;
	logic [9:0]       den;
	logic [8:0]       num;

	logic             valid_s1;
	logic [10:0]      k4_s1;
	logic [9:0]       den_s1;
	logic [8:0]       num_s1, n_s1;
	logic [1:0]       job_s1;

	logic [10:0]      r;
	logic [2:0]       q;
	logic             qi;
	logic [8:0]       r0;

	logic             valid_s2;
	logic [9:0]       t_s2, den_s2;
	logic [1:0]       q0_s2, job_s2;
	logic             qi_s2;
	logic [8:0]       r0_s2, n_s2;

	logic [DIV_STEPS-1:0] feed_b;
	logic [DIV_STEPS-1:0] quo_a, quo_b;
	logic [9:0]           rem_a, rem_b;

	logic       dv_valid_q [DIV_STEPS];
	logic [1:0] dv_q0_q    [DIV_STEPS];
	logic       dv_qi_q    [DIV_STEPS];
	logic [1:0] dv_job_q   [DIV_STEPS];

	logic [29:0] xa;
	logic [30:0] xb;
	logic [1:0]  q0, q1;

	logic        valid_s3;
	logic [30:0] x0_s3, x1_s3;
	logic        neg0_s3, neg1_s3;
	logic [16:0] tex_s3;
	logic [1:0]  job_s3;

	logic        sn_valid_q [L];
	logic        sn_neg0_q  [L];
	logic        sn_neg1_q  [L];
	logic [16:0] sn_tex_q   [L];
	logic [1:0]  sn_job_q   [L];

	logic [30:0] s0, s1;
	logic [31:0] ysum;
	logic [15:0] py;
	rec_t        asm_q, rec_d;

	// configuration and item intake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subdiv_q <= SUBDIV_RESET;
		end else if (cfg_we) begin
			subdiv_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (subdiv_q == 9'd0) begin
			n_eff = 9'd1;
		end else if (subdiv_q > NCAP) begin
			n_eff = NCAP;
		end else begin
			n_eff = subdiv_q;
		end
	end

	assign lat_c = ({1'b0, s_tdata[7:0]} >= n_eff) ? 8'(n_eff - 9'd1) : s_tdata[7:0];
	assign lon_c = ({1'b0, s_tdata[15:8]} >= n_eff) ? 8'(n_eff - 9'd1) : s_tdata[15:8];

	assign s_tready = (!busy_q || job_q == JOB_COL1) && (cnt_q < CNT_W'(QDEPTH));
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			job_q  <= JOB_ROW0;
			cnt_q  <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(accept) - CNT_W'(pop);
			if (accept) begin
				busy_q <= 1'b1;
				job_q  <= JOB_ROW0;
			end else if (busy_q) begin
				if (job_q == JOB_COL1) begin
					busy_q <= 1'b0;
				end
				job_q <= job_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n_eff;
			i_q <= lat_c;
			j_q <= lon_c;
		end
	end

	// job issue
	assign row = !job_q[1];
	assign off = {8'b0, job_q[0]};
	assign k   = (row ? {1'b0, i_q} : {1'b0, j_q}) + off;
	assign den = row ? {n_q, 1'b0} : {1'b0, n_q};
	assign num = row ? n_q - {1'b0, i_q} - off : k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= busy_q;
			valid_s2 <= valid_s1;
			valid_s3 <= dv_valid_q[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		k4_s1  <= {k, 2'b00};
		den_s1 <= den;
		num_s1 <= num;
		n_s1   <= n_q;
		job_s1 <= job_q;
	end

	// quadrant and remainder of the angle, integer part of the texcoord
	always_comb begin
		r = k4_s1;
		q = 3'd0;
		for (int it = 0; it < 4; it++) begin
			if (r >= {1'b0, den_s1}) begin
				r = r - {1'b0, den_s1};
				q = q + 3'd1;
			end
		end
	end

	assign qi = num_s1 >= n_s1;
	assign r0 = qi ? num_s1 - n_s1 : num_s1;

	always_ff @(posedge clk) begin
		t_s2   <= r[9:0];
		den_s2 <= den_s1;
		q0_s2  <= q[1:0];
		job_s2 <= job_s1;
		qi_s2  <= qi;
		r0_s2  <= r0;
		n_s2   <= n_s1;
	end

	// rounding half subdivision fed below the binary point
	assign feed_b = {8'b0, n_s2[8:1], {(DIV_STEPS - 16){1'b0}}};

	uvs_div u_div_ang (
		.clk     (clk),
		.rem_in  (t_s2),
		.den_in  (den_s2),
		.feed_in ('0),
		.quo_out (quo_a),
		.rem_out (rem_a)
	);

	uvs_div u_div_tex (
		.clk     (clk),
		.rem_in  ({1'b0, r0_s2}),
		.den_in  ({1'b0, n_s2}),
		.feed_in (feed_b),
		.quo_out (quo_b),
		.rem_out (rem_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < DIV_STEPS; g++) begin
				dv_valid_q[g] <= 1'b0;
			end
		end else begin
			dv_valid_q[0] <= valid_s2;
			for (int g = 1; g < DIV_STEPS; g++) begin
				dv_valid_q[g] <= dv_valid_q[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		dv_q0_q[0]  <= q0_s2;
		dv_qi_q[0]  <= qi_s2;
		dv_job_q[0] <= job_s2;
		for (int g = 1; g < DIV_STEPS; g++) begin
			dv_q0_q[g]  <= dv_q0_q[g-1];
			dv_qi_q[g]  <= dv_qi_q[g-1];
			dv_job_q[g] <= dv_job_q[g-1];
		end
	end

	// fold for odd quadrants
	assign xa = quo_a;
	assign xb = Q30_ONE - {1'b0, xa} - 31'(rem_a != 10'd0);
	assign q0 = dv_q0_q[DIV_STEPS-1];
	assign q1 = q0 + 2'd1;

	always_ff @(posedge clk) begin
		x0_s3   <= q0[0] ? xb : {1'b0, xa};
		x1_s3   <= q0[0] ? {1'b0, xa} : xb;
		neg0_s3 <= q0[1];
		neg1_s3 <= q1[1];
		tex_s3  <= {dv_qi_q[DIV_STEPS-1], quo_b[DIV_STEPS-1 -: 16]} | 17'(rem_b & 10'd0);
		job_s3  <= dv_job_q[DIV_STEPS-1];
	end

	uvs_qsin u_qsin_0 (
		.clk (clk),
		.x   (x0_s3),
		.s   (s0)
	);

	uvs_qsin u_qsin_1 (
		.clk (clk),
		.x   (x1_s3),
		.s   (s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < L; g++) begin
				sn_valid_q[g] <= 1'b0;
			end
		end else begin
			sn_valid_q[0] <= valid_s3;
			for (int g = 1; g < L; g++) begin
				sn_valid_q[g] <= sn_valid_q[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		sn_neg0_q[0] <= neg0_s3;
		sn_neg1_q[0] <= neg1_s3;
		sn_tex_q[0]  <= tex_s3;
		sn_job_q[0]  <= job_s3;
		for (int g = 1; g < L; g++) begin
			sn_neg0_q[g] <= sn_neg0_q[g-1];
			sn_neg1_q[g] <= sn_neg1_q[g-1];
			sn_tex_q[g]  <= sn_tex_q[g-1];
			sn_job_q[g]  <= sn_job_q[g-1];
		end
	end

	// gather the four jobs of a cell
	assign ysum = {1'b0, s1} + 32'h0000_8000;
	assign py   = pos_round({1'b0, ysum[31:16]}, !sn_neg1_q[L-1]);

	always_comb begin
		rec_d = asm_q;
		unique case (sn_job_q[L-1])
			JOB_ROW0: begin
				rec_d.lat_cos_mag[0] = s0;
				rec_d.lat_cos_neg[0] = sn_neg0_q[L-1];
				rec_d.pos_y[0]       = py;
				rec_d.tex_v[0]       = sn_tex_q[L-1];
			end
			JOB_ROW1: begin
				rec_d.lat_cos_mag[1] = s0;
				rec_d.lat_cos_neg[1] = sn_neg0_q[L-1];
				rec_d.pos_y[1]       = py;
				rec_d.tex_v[1]       = sn_tex_q[L-1];
			end
			JOB_COL0: begin
				rec_d.lon_sin_mag[0] = s0;
				rec_d.lon_sin_neg[0] = sn_neg0_q[L-1];
				rec_d.lon_cos_mag[0] = s1;
				rec_d.lon_cos_neg[0] = sn_neg1_q[L-1];
				rec_d.tex_u[0]       = sn_tex_q[L-1];
			end
			JOB_COL1: begin
				rec_d.lon_sin_mag[1] = s0;
				rec_d.lon_sin_neg[1] = sn_neg0_q[L-1];
				rec_d.lon_cos_mag[1] = s1;
				rec_d.lon_cos_neg[1] = sn_neg1_q[L-1];
				rec_d.tex_u[1]       = sn_tex_q[L-1];
			end
			default: begin
				rec_d = asm_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sn_valid_q[L-1]) begin
			asm_q <= rec_d;
		end
	end

	assign rec_valid = sn_valid_q[L-1] && sn_job_q[L-1] == JOB_COL1;
	assign rec       = rec_d;

endmodule

>>> design/uvs_back.sv
module uvs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	input  uvs_pkg::rec_t rec,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [87:0]   m_tdata,
	output logic          m_tlast
);
	import uvs_pkg::*;

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [2:0]        corner_q;

	rec_t        head;
	logic        have, issue, out_adv, s1_adv;
	logic        a, b;
	logic [61:0] px, pz;

	logic        valid_s1;
	logic [61:0] px_s1, pz_s1;
	logic        negx_s1, negz_s1;
	logic [15:0] py_s1;
	logic [16:0] u_s1, v_s1;
	logic [2:0]  corner_s1;
	logic        last_s1;

	logic [62:0] sx, sz;

	// cell queue
	always_ff @(posedge clk) begin
		if (rec_valid) begin
			mem_q[wr_ptr_q] <= rec;
		end
	end

	assign head    = mem_q[rd_ptr_q];
	assign have    = cnt_q != '0;
	assign out_adv = !m_tvalid || m_tready;
	assign s1_adv  = !valid_s1 || out_adv;
	assign issue   = have && s1_adv;
	assign pop     = issue && corner_q == CORNER_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			corner_q <= '0;
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(rec_valid) - CNT_W'(pop);
			if (rec_valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (issue) begin
				corner_q <= (corner_q == CORNER_LAST) ? 3'd0 : corner_q + 3'd1;
			end
			if (s1_adv) begin
				valid_s1 <= issue;
			end
			if (out_adv) begin
				m_tvalid <= valid_s1;
			end
		end
	end

	// vertex products
	assign a  = CORNER_ROW[corner_q];
	assign b  = CORNER_COL[corner_q];
	assign px = head.lat_cos_mag[a] * head.lon_cos_mag[b];
	assign pz = head.lat_cos_mag[a] * head.lon_sin_mag[b];

	always_ff @(posedge clk) begin
		if (issue) begin
			px_s1     <= px;
			pz_s1     <= pz;
			negx_s1   <= head.lat_cos_neg[a] ^ head.lon_cos_neg[b];
			negz_s1   <= head.lat_cos_neg[a] ^ head.lon_sin_neg[b];
			py_s1     <= head.pos_y[a];
			u_s1      <= head.tex_u[b];
			v_s1      <= head.tex_v[a];
			corner_s1 <= corner_q;
			last_s1   <= corner_q == CORNER_LAST;
		end
	end

	// round half away from zero
	assign sx = {1'b0, px_s1} + 63'h0000_2000_0000_0000;
	assign sz = {1'b0, pz_s1} + 63'h0000_2000_0000_0000;

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			m_tdata <= {3'b000, corner_s1, v_s1, u_s1,
				pos_round(sz[62:46], negz_s1), py_s1, pos_round(sx[62:46], negx_s1)};
			m_tlast <= last_s1;
		end
	end

endmodule

>>> design/uv_sphere_cell_vertex_generator.sv
// channel  direction  tdata (low bit up)                                   tlast
// s_*      in         lat_index[7:0] lon_index[15:8]                      -
// m_*      out        pos_x pos_y pos_z tex_u tex_v corner, zero pad      last
// cfg_*    in         subdivisions[8:0], written when cfg_we is high      -
//
// the output channel sets the sustained cell rate (one vertex a cycle unless m_tready stalls it)
// from input to its first vertex, a cell's four angle jobs pass
// through a 30-stage pipelined divider and a 6-stage polynomial sine pipeline
// arst_n clears the handshakes and queue; subdivisions resets to 16
// up to 16 cells may be in flight; s_tready drops when their queue slots are used
module uv_sphere_cell_vertex_generator #(
	parameter int MAX_SUBDIV = uvs_pkg::MAX_SUBDIV_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // lat_index, lon_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, corner
	output logic        m_tlast
);
	import uvs_pkg::*;

	rec_t rec;
	logic rec_valid;
	logic pop;

	uvs_front #(
		.MAX_SUBDIV (MAX_SUBDIV)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.pop       (pop),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	uvs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
